### rtl/ggd_pkg.sv
// Package for the gyro gesture detector: register indexes, reset values,
// and the structs shared by the detector modules. No dependencies.

package ggd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_TRIGGER_THRESHOLD = 3'd0;
   localparam csr_index_type CSR_RELEASE_FRACTION  = 3'd1;
   localparam csr_index_type CSR_DETECT_WINDOW     = 3'd2;
   localparam csr_index_type CSR_DEBOUNCE          = 3'd3;
   localparam csr_index_type CSR_COOLDOWN          = 3'd4;

   localparam logic [15:0] THRESHOLD_RST = 16'd2000;
   localparam logic [8:0]  FRACTION_RST  = 9'd128;
   localparam logic [15:0] WINDOW_RST    = 16'd500;
   localparam logic [15:0] DEBOUNCE_RST  = 16'd100;
   localparam logic [15:0] COOLDOWN_RST  = 16'd300;
   // Derived values for the reset threshold and fraction.
   localparam logic [31:0] THR_SQ_RST    = 32'd4000000;
   localparam logic [24:0] THR_FRAC_RST  = 25'd256000;

   typedef struct packed {
      logic [31:0] thr_sq;        // threshold squared
      logic [24:0] thr_frac;      // threshold times release fraction (q8)
      logic [15:0] detect_window;
      logic [15:0] debounce;
      logic [15:0] cooldown;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
      logic [31:0]        time_ms;
      logic [31:0]        energy;
   } sample_type;

endpackage

### rtl/ggd_if.sv
// Valid/ready channel interfaces for the gyro gesture detector:
// one for gyro samples in, one for results out. No dependencies.

interface ggd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   logic signed [15:0] rate_z;
   logic [31:0]        time_ms;

   modport source (output valid, rate_x, rate_y, rate_z, time_ms, input ready);
   modport sink   (input valid, rate_x, rate_y, rate_z, time_ms, output ready);
endinterface

interface ggd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         gesture_code;
   logic [1:0]         mode_now;
   logic signed [15:0] held_peak_x;
   logic signed [15:0] held_peak_y;
   logic signed [15:0] held_peak_z;
   logic [31:0]        held_peak_energy;

   modport source (output valid, gesture_code, mode_now, held_peak_x, held_peak_y,
                   held_peak_z, held_peak_energy, input ready);
   modport sink   (input valid, gesture_code, mode_now, held_peak_x, held_peak_y,
                   held_peak_z, held_peak_energy, output ready);
endinterface

### rtl/ggd_csr.sv
// Configuration registers of the gyro gesture detector, with the squared
// threshold and threshold-times-fraction products kept ready. Uses ggd_pkg.

module ggd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  ggd_pkg::csr_index_type          csr_index,
   input  logic [ggd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output ggd_pkg::cfg_type                cfg
);

   logic [15:0] thr_ff, thr_in;
   logic [8:0]  frac_ff, frac_in;
   logic [15:0] window_ff, window_in;
   logic [15:0] debounce_ff, debounce_in;
   logic [15:0] cooldown_ff, cooldown_in;
   logic [31:0] thr_sq_ff, thr_sq_in;
   logic [24:0] thr_frac_ff, thr_frac_in;

   // The products are formed at write time so the sample path only sees registers.
   always_comb begin
      thr_in      = thr_ff;
      frac_in     = frac_ff;
      window_in   = window_ff;
      debounce_in = debounce_ff;
      cooldown_in = cooldown_ff;
      thr_sq_in   = thr_sq_ff;
      thr_frac_in = thr_frac_ff;
      if (csr_we) begin
         unique case (csr_index)
            ggd_pkg::CSR_TRIGGER_THRESHOLD: begin
               thr_in      = csr_wdata;
               thr_sq_in   = 32'(csr_wdata) * 32'(csr_wdata);
               thr_frac_in = 25'(csr_wdata) * 25'(frac_ff);
            end
            ggd_pkg::CSR_RELEASE_FRACTION: begin
               frac_in     = csr_wdata[8:0];
               thr_frac_in = 25'(thr_ff) * 25'(csr_wdata[8:0]);
            end
            ggd_pkg::CSR_DETECT_WINDOW: window_in   = csr_wdata;
            ggd_pkg::CSR_DEBOUNCE:      debounce_in = csr_wdata;
            ggd_pkg::CSR_COOLDOWN:      cooldown_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= ggd_pkg::THRESHOLD_RST;
         frac_ff     <= ggd_pkg::FRACTION_RST;
         window_ff   <= ggd_pkg::WINDOW_RST;
         debounce_ff <= ggd_pkg::DEBOUNCE_RST;
         cooldown_ff <= ggd_pkg::COOLDOWN_RST;
         thr_sq_ff   <= ggd_pkg::THR_SQ_RST;
         thr_frac_ff <= ggd_pkg::THR_FRAC_RST;
      end else begin
         thr_ff      <= thr_in;
         frac_ff     <= frac_in;
         window_ff   <= window_in;
         debounce_ff <= debounce_in;
         cooldown_ff <= cooldown_in;
         thr_sq_ff   <= thr_sq_in;
         thr_frac_ff <= thr_frac_in;
      end
   end

   assign cfg.thr_sq        = thr_sq_ff;
   assign cfg.thr_frac      = thr_frac_ff;
   assign cfg.detect_window = window_ff;
   assign cfg.debounce      = debounce_ff;
   assign cfg.cooldown      = cooldown_ff;

endmodule

### rtl/ggd_front.sv
// Input register of the gyro gesture detector: takes a sample transfer and
// stores it with its squared magnitude. Uses ggd_pkg and ggd_req_if.

module ggd_front (
   input  logic                clock,
   input  logic                reset,
   ggd_req_if.sink             req_ch,
   input  logic                pipe_adv,
   output logic                sample_valid,
   output ggd_pkg::sample_type sample
);

   logic                valid_ff, valid_in;
   ggd_pkg::sample_type sample_ff, sample_in;
   logic signed [31:0]  wide_x, wide_y, wide_z;
   logic [31:0]         sq_x, sq_y, sq_z;
   logic                take;

   assign req_ch.ready = !valid_ff || pipe_adv;
   assign take         = req_ch.valid && req_ch.ready;

   assign wide_x = 32'(req_ch.rate_x);
   assign wide_y = 32'(req_ch.rate_y);
   assign wide_z = 32'(req_ch.rate_z);
   assign sq_x   = 32'(wide_x * wide_x);
   assign sq_y   = 32'(wide_y * wide_y);
   assign sq_z   = 32'(wide_z * wide_z);

   always_comb begin
      valid_in  = req_ch.ready ? req_ch.valid : valid_ff;
      sample_in = sample_ff;
      if (take) begin
         sample_in.rate_x  = req_ch.rate_x;
         sample_in.rate_y  = req_ch.rate_y;
         sample_in.rate_z  = req_ch.rate_z;
         sample_in.time_ms = req_ch.time_ms;
         // Each square is at most 2^30, so the sum fits in 32 bits.
         sample_in.energy  = sq_x + sq_y + sq_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      sample_ff <= sample_in;
   end

   assign sample_valid = valid_ff;
   assign sample       = sample_ff;

endmodule

### rtl/ggd_fsm.sv
// Gesture state machine and result register of the gyro gesture detector:
// peak tracking, release test, classification and timeouts.
// Uses ggd_pkg and ggd_rsp_if.

module ggd_fsm (
   input  logic                clock,
   input  logic                reset,
   input  ggd_pkg::cfg_type    cfg,
   input  logic                sample_valid,
   input  ggd_pkg::sample_type sample,
   output logic                pipe_adv,
   ggd_rsp_if.source           rsp_ch
);

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_DETECTING = 2'd1,
      MODE_DEBOUNCE  = 2'd2,
      MODE_COOLDOWN  = 2'd3
   } mode_type;

   localparam logic [2:0] GESTURE_NIL   = 3'd0;
   localparam logic [2:0] GESTURE_LEFT  = 3'd1;
   localparam logic [2:0] GESTURE_RIGHT = 3'd2;
   localparam logic [2:0] GESTURE_UP    = 3'd3;
   localparam logic [2:0] GESTURE_DOWN  = 3'd4;
   localparam logic [2:0] GESTURE_CW    = 3'd5;
   localparam logic [2:0] GESTURE_CCW   = 3'd6;

   mode_type           mode_ff, mode_in;
   logic               near_miss_ff, near_miss_in;
   logic [31:0]        start_ff, start_in;
   logic [31:0]        end_ff, end_in;
   logic signed [15:0] peak_x_ff, peak_x_in;
   logic signed [15:0] peak_y_ff, peak_y_in;
   logic signed [15:0] peak_z_ff, peak_z_in;
   logic [31:0]        peak_e_ff, peak_e_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         code_ff, code_in;
   mode_type           out_mode_ff;
   logic signed [15:0] out_x_ff, out_y_ff, out_z_ff;
   logic [31:0]        out_e_ff;

   logic               step;
   logic               above, near, peak_hit, release_hit;
   logic               window_over, debounce_done, cooldown_done;
   logic [38:0]        energy_x100, thr_sq_x81;
   logic [49:0]        energy_shl, thr_frac_sq;
   logic [31:0]        since_start, since_end;
   logic signed [15:0] cand_x, cand_y, cand_z;
   logic [31:0]        cand_e;

   // Dominant axis of the peak and its sign; a tie for largest gives none.
   function automatic logic [2:0] classify(input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic signed [15:0] z);
      logic signed [16:0] xe, ye, ze;
      logic [16:0]        ax, ay, az;
      logic [2:0]         code;
      xe = 17'(x);
      ye = 17'(y);
      ze = 17'(z);
      ax = (xe < 0) ? 17'(-xe) : 17'(xe);
      ay = (ye < 0) ? 17'(-ye) : 17'(ye);
      az = (ze < 0) ? 17'(-ze) : 17'(ze);
      priority if (ax > ay && ax > az) begin
         code = (x > 0) ? GESTURE_DOWN : GESTURE_UP;
      end else if (ay > ax && ay > az) begin
         code = (y > 0) ? GESTURE_LEFT : GESTURE_RIGHT;
      end else if (az > ax && az > ay) begin
         code = (z > 0) ? GESTURE_CW : GESTURE_CCW;
      end else begin
         code = GESTURE_NIL;
      end
      return code;
   endfunction

   assign pipe_adv = !rsp_valid_ff || rsp_ch.ready;
   assign step     = sample_valid && pipe_adv;

   assign above       = sample.energy > cfg.thr_sq;
   assign energy_x100 = 39'(sample.energy) * 39'd100;
   assign thr_sq_x81  = 39'(cfg.thr_sq) * 39'd81;
   assign near        = energy_x100 > thr_sq_x81;
   assign peak_hit    = sample.energy > peak_e_ff;
   // Magnitude below T*F/256, compared as squares scaled by 2^16.
   assign energy_shl  = {2'b00, sample.energy, 16'h0000};
   assign thr_frac_sq = 50'(cfg.thr_frac) * 50'(cfg.thr_frac);
   assign release_hit = energy_shl < thr_frac_sq;

   assign since_start   = sample.time_ms - start_ff;
   assign since_end     = sample.time_ms - end_ff;
   assign window_over   = since_start > 32'(cfg.detect_window);
   assign debounce_done = since_end >= 32'(cfg.debounce);
   assign cooldown_done = since_end >= 32'(cfg.cooldown);

   // Peak after the detecting-mode update, which comes before the release test.
   assign cand_x = peak_hit ? sample.rate_x : peak_x_ff;
   assign cand_y = peak_hit ? sample.rate_y : peak_y_ff;
   assign cand_z = peak_hit ? sample.rate_z : peak_z_ff;
   assign cand_e = peak_hit ? sample.energy : peak_e_ff;

   always_comb begin
      mode_in      = mode_ff;
      near_miss_in = near_miss_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      peak_x_in    = peak_x_ff;
      peak_y_in    = peak_y_ff;
      peak_z_in    = peak_z_ff;
      peak_e_in    = peak_e_ff;
      code_in      = GESTURE_NIL;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (above) begin
               mode_in      = MODE_DETECTING;
               start_in     = sample.time_ms;
               peak_x_in    = sample.rate_x;
               peak_y_in    = sample.rate_y;
               peak_z_in    = sample.rate_z;
               peak_e_in    = sample.energy;
               near_miss_in = 1'b0;
            end else if (near) begin
               if (!near_miss_ff) begin
                  peak_x_in = sample.rate_x;
                  peak_y_in = sample.rate_y;
                  peak_z_in = sample.rate_z;
                  peak_e_in = sample.energy;
               end
               near_miss_in = 1'b1;
            end else begin
               near_miss_in = 1'b0;
            end
         end
         MODE_DETECTING: begin
            peak_x_in = cand_x;
            peak_y_in = cand_y;
            peak_z_in = cand_z;
            peak_e_in = cand_e;
            if (release_hit) begin
               if (cand_e >= cfg.thr_sq) begin
                  code_in = classify(cand_x, cand_y, cand_z);
               end
               end_in  = sample.time_ms;
               mode_in = MODE_DEBOUNCE;
            end else if (window_over) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_DEBOUNCE: begin
            if (debounce_done) begin
               mode_in = MODE_COOLDOWN;
            end
         end
         MODE_COOLDOWN: begin
            if (cooldown_done) begin
               mode_in      = MODE_IDLE;
               near_miss_in = 1'b0;
            end
         end
      endcase
      rsp_valid_in = pipe_adv ? sample_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         near_miss_ff <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
         peak_x_ff    <= '0;
         peak_y_ff    <= '0;
         peak_z_ff    <= '0;
         peak_e_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            mode_ff      <= mode_in;
            near_miss_ff <= near_miss_in;
            start_ff     <= start_in;
            end_ff       <= end_in;
            peak_x_ff    <= peak_x_in;
            peak_y_ff    <= peak_y_in;
            peak_z_ff    <= peak_z_in;
            peak_e_ff    <= peak_e_in;
         end
      end
      if (step) begin
         code_ff     <= code_in;
         out_mode_ff <= mode_in;
         out_x_ff    <= peak_x_in;
         out_y_ff    <= peak_y_in;
         out_z_ff    <= peak_z_in;
         out_e_ff    <= peak_e_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.gesture_code     = code_ff;
   assign rsp_ch.mode_now         = out_mode_ff;
   assign rsp_ch.held_peak_x      = out_x_ff;
   assign rsp_ch.held_peak_y      = out_y_ff;
   assign rsp_ch.held_peak_z      = out_z_ff;
   assign rsp_ch.held_peak_energy = out_e_ff;

   // The mode only moves when a sample is processed.
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(mode_ff))
      else $error("mode changed without a processed sample");

   // Debounce can only stay or move on to cooldown.
   assert property (@(posedge clock) disable iff (reset)
      step && mode_ff == MODE_DEBOUNCE |=>
         mode_ff == MODE_DEBOUNCE || mode_ff == MODE_COOLDOWN)
      else $error("illegal exit from debounce");

   // A gesture is only ever reported on the step that enters debounce.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && code_ff != GESTURE_NIL |-> out_mode_ff == MODE_DEBOUNCE)
      else $error("gesture reported outside debounce entry");

   // The near-miss flag is only held while idle.
   assert property (@(posedge clock) disable iff (reset)
      near_miss_ff |-> mode_ff == MODE_IDLE)
      else $error("near-miss flag set outside idle");

endmodule

### rtl/gyro_gesture_detector.sv
// Top level of the gyro gesture detector.
// Uses ggd_pkg, ggd_if, ggd_csr, ggd_front and ggd_fsm.
//
// Usage:
//   req_ch carries one gyro sample per transfer (three signed axes and a
//   millisecond timestamp); rsp_ch returns exactly one result per sample:
//   a gesture code, the mode after the sample and the held peak sample.
//   Both are valid/ready channels; a transfer happens on a rising edge with
//   valid and ready high.
//   The csr_ port writes registers 0..4 (threshold, release fraction,
//   detect window, debounce, cooldown) on any edge with csr_we high. Write
//   them only while no sample is in flight.
//   A sample passes through the input register, then the result register.
//   Throughput: one sample per cycle while rsp_ch.ready stays high, set by
//   the input register and the state update feeding the result register.
//   While the result register waits on rsp_ch.ready, one more sample is
//   still taken into the input register; req_ch.ready then drops until the
//   result is taken.
//   Synchronous reset restores the register defaults, returns to idle,
//   clears the held peak and empties both pipeline registers.

module gyro_gesture_detector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  ggd_pkg::csr_index_type         csr_index,
   input  logic [ggd_pkg::CSR_DATA_W-1:0] csr_wdata,
   ggd_req_if.sink                        req_ch,
   ggd_rsp_if.source                      rsp_ch
);

   ggd_pkg::cfg_type    cfg;
   ggd_pkg::sample_type sample;
   logic                sample_valid;
   logic                pipe_adv;

   ggd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ggd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .pipe_adv     (pipe_adv),
      .sample_valid (sample_valid),
      .sample       (sample)
   );

   ggd_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .sample_valid (sample_valid),
      .sample       (sample),
      .pipe_adv     (pipe_adv),
      .rsp_ch       (rsp_ch)
   );

endmodule

### tb/ggd_result_checker.sv
// Result checker for the gyro gesture detector: watches the register port and
// the sample and result channels, predicts each result, compares field by field.
// Depends on ggd_pkg and the channel interfaces in ggd_if.
`timescale 1ns / 1ps

module ggd_result_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  ggd_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata,
   ggd_req_if                     req_ch,
   ggd_rsp_if                     rsp_ch,
   output int unsigned            error_count,
   output int unsigned            open_count
);

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_DETECTING = 2'd1,
      MODE_DEBOUNCE  = 2'd2,
      MODE_COOLDOWN  = 2'd3
   } det_mode_type;

   localparam logic [2:0] GESTURE_NIL   = 3'd0;
   localparam logic [2:0] GESTURE_LEFT  = 3'd1;
   localparam logic [2:0] GESTURE_RIGHT = 3'd2;
   localparam logic [2:0] GESTURE_UP    = 3'd3;
   localparam logic [2:0] GESTURE_DOWN  = 3'd4;
   localparam logic [2:0] GESTURE_CW    = 3'd5;
   localparam logic [2:0] GESTURE_CCW   = 3'd6;

   typedef struct packed {
      logic [2:0]         code;
      logic [1:0]         mode;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      logic [31:0]        energy;
   } gesture_result_type;

   // Register shadow.
   logic [15:0] thr_q;
   logic [8:0]  frac_q;
   logic [15:0] window_q;
   logic [15:0] debounce_q;
   logic [15:0] cooldown_q;

   // Detector state shadow.
   det_mode_type       mode_q;
   logic [31:0]        start_ms;
   logic [31:0]        end_ms;
   logic signed [15:0] peak_x;
   logic signed [15:0] peak_y;
   logic signed [15:0] peak_z;
   logic [31:0]        peak_e;
   logic               near_miss;

   gesture_result_type pending_results[$];
   int unsigned        errors;

   assign error_count = errors;

   function automatic void capture_peak(logic signed [15:0] x, logic signed [15:0] y,
                                        logic signed [15:0] z, logic [31:0] e);
      peak_x = x;
      peak_y = y;
      peak_z = z;
      peak_e = e;
   endfunction

   // The peak axis must be strictly larger than both others, else no gesture.
   function automatic logic [2:0] dominant_gesture();
      int vx, vy, vz;
      int ax, ay, az;
      vx = int'(peak_x);
      vy = int'(peak_y);
      vz = int'(peak_z);
      ax = (vx < 0) ? -vx : vx;
      ay = (vy < 0) ? -vy : vy;
      az = (vz < 0) ? -vz : vz;
      if (ax > ay && ax > az) return (vx > 0) ? GESTURE_DOWN : GESTURE_UP;
      if (ay > ax && ay > az) return (vy > 0) ? GESTURE_LEFT : GESTURE_RIGHT;
      if (az > ax && az > ay) return (vz > 0) ? GESTURE_CW : GESTURE_CCW;
      return GESTURE_NIL;
   endfunction

   function automatic gesture_result_type next_gesture_result(logic signed [15:0] x,
                                                              logic signed [15:0] y,
                                                              logic signed [15:0] z,
                                                              logic [31:0] now);
      logic signed [63:0] sx, sy, sz;
      logic [63:0]        energy, thr_w, thr_sq, release_sq, thr_frac;
      logic [31:0]        since_start, since_end;
      gesture_result_type r;
      sx = 64'(x);
      sy = 64'(y);
      sz = 64'(z);
      energy = sx * sx + sy * sy + sz * sz;
      thr_w = 64'(thr_q);
      thr_sq = thr_w * thr_w;
      thr_frac = thr_w * 64'(frac_q);
      release_sq = thr_frac * thr_frac;
      since_start = now - start_ms;
      since_end = now - end_ms;
      r.code = GESTURE_NIL;
      case (mode_q)
         MODE_IDLE: begin
            if (energy > thr_sq) begin
               mode_q = MODE_DETECTING;
               start_ms = now;
               capture_peak(x, y, z, energy[31:0]);
               near_miss = 1'b0;
            end else if (energy * 100 > thr_sq * 81) begin
               // Only the first sample of a run of near misses is held.
               if (!near_miss) begin
                  capture_peak(x, y, z, energy[31:0]);
                  near_miss = 1'b1;
               end
            end else begin
               near_miss = 1'b0;
            end
         end
         MODE_DETECTING: begin
            if (energy[31:0] > peak_e) capture_peak(x, y, z, energy[31:0]);
            if (energy * 65536 < release_sq) begin
               if ({32'd0, peak_e} >= thr_sq) r.code = dominant_gesture();
               end_ms = now;
               mode_q = MODE_DEBOUNCE;
            end else if (since_start > {16'd0, window_q}) begin
               mode_q = MODE_IDLE;
            end
         end
         MODE_DEBOUNCE: begin
            if (since_end >= {16'd0, debounce_q}) mode_q = MODE_COOLDOWN;
         end
         MODE_COOLDOWN: begin
            if (since_end >= {16'd0, cooldown_q}) begin
               mode_q = MODE_IDLE;
               near_miss = 1'b0;
            end
         end
      endcase
      r.mode = mode_q;
      r.px = peak_x;
      r.py = peak_y;
      r.pz = peak_z;
      r.energy = peak_e;
      return r;
   endfunction

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      gesture_result_type want;
      if (reset) begin
         thr_q = ggd_pkg::THRESHOLD_RST;
         frac_q = ggd_pkg::FRACTION_RST;
         window_q = ggd_pkg::WINDOW_RST;
         debounce_q = ggd_pkg::DEBOUNCE_RST;
         cooldown_q = ggd_pkg::COOLDOWN_RST;
         mode_q = MODE_IDLE;
         start_ms = '0;
         end_ms = '0;
         capture_peak('0, '0, '0, '0);
         near_miss = 1'b0;
         pending_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               ggd_pkg::CSR_TRIGGER_THRESHOLD: thr_q = csr_wdata;
               ggd_pkg::CSR_RELEASE_FRACTION:  frac_q = csr_wdata[8:0];
               ggd_pkg::CSR_DETECT_WINDOW:     window_q = csr_wdata;
               ggd_pkg::CSR_DEBOUNCE:          debounce_q = csr_wdata;
               ggd_pkg::CSR_COOLDOWN:          cooldown_q = csr_wdata;
               default: ;
            endcase
         end
         // Results are checked before this edge's sample is predicted, so a
         // stray result can never be matched against a fresh expectation.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result transfer with nothing expected, %s %0d mode_now %0d",
                        $time, "actual gesture_code", rsp_ch.gesture_code,
                        rsp_ch.mode_now);
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("gesture_code", longint'(want.code),
                           longint'(rsp_ch.gesture_code));
               check_field("mode_now", longint'(want.mode), longint'(rsp_ch.mode_now));
               check_field("held_peak_x", longint'(want.px), longint'(rsp_ch.held_peak_x));
               check_field("held_peak_y", longint'(want.py), longint'(rsp_ch.held_peak_y));
               check_field("held_peak_z", longint'(want.pz), longint'(rsp_ch.held_peak_z));
               check_field("held_peak_energy", longint'(want.energy),
                           longint'(rsp_ch.held_peak_energy));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_results.push_back(next_gesture_result(req_ch.rate_x, req_ch.rate_y,
                                                          req_ch.rate_z, req_ch.time_ms));
         end
      end
      open_count <= pending_results.size();
   end

endmodule

### tb/tb_gyro_gesture_detector.sv
// Testbench top for the gyro gesture detector: clock, reset, register writes,
// gyro sample stimulus with bursty sending and a stalling result receiver.
// Depends on ggd_pkg, ggd_if, the detector RTL and ggd_result_checker.
`timescale 1ns / 1ps

module tb_gyro_gesture_detector;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [31:0]        t;
   } gyro_sample_type;

   typedef enum int {FREE_FLOW, LIGHT_STALL, HEAVY_STALL, LONG_STALL} stall_style_type;

   localparam ggd_pkg::csr_index_type CSR_UNMAPPED = 3'd7;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_LIMIT    = 2000;
   localparam int MAX_AXIS      = 32767;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   ggd_pkg::csr_index_type csr_index;
   logic [15:0]            csr_wdata;
   int unsigned            error_count;
   int unsigned            open_count;
   int unsigned            quiet_cycles;

   gyro_sample_type sample_q[$];
   logic [31:0]     clock_ms;
   int              cur_thr;
   int              cur_frac;
   int              burst_left;

   ggd_req_if req_ch ();
   ggd_rsp_if rsp_ch ();

   gyro_gesture_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   ggd_result_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .error_count (error_count),
      .open_count  (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver switches between randomly chosen stall styles.
   initial begin
      stall_style_type style;
      int              left;
      rsp_ch.ready = 1'b0;
      style = FREE_FLOW;
      left = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            style = stall_style_type'($urandom_range(0, 3));
            left = $urandom_range(20, 200);
         end
         left--;
         case (style)
            FREE_FLOW:   rsp_ch.ready <= 1'b1;
            LIGHT_STALL: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
            HEAVY_STALL: rsp_ch.ready <= ($urandom_range(0, 2) == 0);
            default:     rsp_ch.ready <= ((left % 24) < 3);
         endcase
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   function automatic int limit_mag(int v);
      return (v > MAX_AXIS) ? MAX_AXIS : v;
   endfunction

   // Mostly short steps so debounce and cooldown elapse over several samples,
   // with occasional long jumps and arbitrary jumps across the wrap.
   function automatic logic [31:0] next_stamp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         clock_ms = clock_ms;
      else if (r < 85)
         clock_ms = clock_ms + $urandom_range(1, 60);
      else if (r < 97)
         clock_ms = clock_ms + $urandom_range(61, 1200);
      else if (r < 99)
         clock_ms = clock_ms + $urandom_range(1201, 70000);
      else
         clock_ms = clock_ms + $urandom();
      return clock_ms;
   endfunction

   task automatic push_at(logic signed [15:0] x, logic signed [15:0] y,
                          logic signed [15:0] z, logic [31:0] t);
      gyro_sample_type s;
      s.x = x;
      s.y = y;
      s.z = z;
      s.t = t;
      clock_ms = t;
      sample_q.push_back(s);
   endtask

   task automatic push_raw(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
      push_at(x, y, z, next_stamp());
   endtask

   // One axis carries the requested magnitude; without a tie the other two stay
   // within an eighth of it, so the total lands just above the request.
   task automatic push_shaped(int mag, bit allow_tie);
      int v[3];
      int lead, side, k;
      mag = limit_mag(mag);
      side = mag / 8;
      lead = $urandom_range(0, 2);
      for (k = 0; k < 3; k++) begin
         v[k] = $urandom_range(0, side);
         if ($urandom_range(0, 1)) v[k] = -v[k];
      end
      v[lead] = $urandom_range(0, 1) ? mag : -mag;
      if (allow_tie && $urandom_range(0, 7) == 0)
         v[(lead + 1 + $urandom_range(0, 1)) % 3] = $urandom_range(0, 1) ? mag : -mag;
      push_raw(16'(v[0]), 16'(v[1]), 16'(v[2]));
   endtask

   function automatic logic signed [15:0] extreme_axis();
      case ($urandom_range(0, 5))
         0:       return -16'sd32768;
         1:       return -16'sd32767;
         2:       return -16'sd1;
         3:       return 16'sd0;
         4:       return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   task automatic queue_gesture();
      int release_mag, quiet_hi, near_lo, near_hi;
      release_mag = (cur_thr * cur_frac) / 256;
      quiet_hi = release_mag * 95 / 100;
      if (cur_thr * 85 / 100 < quiet_hi) quiet_hi = cur_thr * 85 / 100;
      quiet_hi = limit_mag(quiet_hi);
      near_lo = limit_mag(cur_thr * 91 / 100 + 1);
      near_hi = limit_mag(cur_thr * 98 / 100);
      repeat ($urandom_range(0, 3)) push_shaped($urandom_range(0, quiet_hi), 1'b0);
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 2)) push_shaped($urandom_range(near_lo, near_hi), 1'b0);
      repeat ($urandom_range(1, 5))
         push_shaped($urandom_range(cur_thr + 1, limit_mag(2 * cur_thr + 1)), 1'b1);
      if ($urandom_range(0, 6) != 0)
         push_shaped($urandom_range(0, quiet_hi), 1'b0);
      else
         push_shaped($urandom_range(limit_mag(release_mag), limit_mag(cur_thr)), 1'b0);
      repeat ($urandom_range(2, 12)) push_shaped($urandom_range(0, quiet_hi), 1'b0);
   endtask

   task automatic queue_random(int count);
      int target, pick;
      target = sample_q.size() + count;
      while (sample_q.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            queue_gesture();
         else if (pick < 88)
            repeat ($urandom_range(1, 4))
               push_raw(16'($urandom()), 16'($urandom()), 16'($urandom()));
         else
            push_raw(extreme_axis(), extreme_axis(), extreme_axis());
      end
   endtask

   // Runs at the reset register values: threshold 2000, release half of it,
   // window 500, debounce 100, cooldown 300.
   task automatic queue_directed();
      push_at(0, 0, 0, 32'd1000);
      push_at(1801, 0, 0, 32'd1010);        // first near miss is held
      push_at(1900, 0, 0, 32'd1020);        // later near misses are not
      push_at(1800, 0, 0, 32'd1030);        // exactly 90 percent clears it
      push_at(-1850, 5, -7, 32'd1040);
      push_at(0, 2000, 0, 32'd1050);        // at threshold does not start
      push_at(0, 2001, 0, 32'd1060);
      push_at(0, -2500, 100, 32'd1070);
      push_at(0, 1000, 0, 32'd1080);        // exactly at release level
      push_at(0, 999, 0, 32'd1090);
      push_at(0, 0, 0, 32'd1189);
      push_at(0, 0, 0, 32'd1190);
      push_at(0, 0, 0, 32'd1389);
      push_at(0, 0, 0, 32'd1390);
      push_at(32767, -32768, -32768, 32'd1400); // tied peak axes
      push_at(0, 0, 0, 32'd1410);
      push_at(0, 0, 0, 32'd6410);           // skips straight past debounce
      push_at(0, 0, 0, 32'd6411);
      push_at(3000, 0, 0, 32'd7000);
      push_at(2500, 0, 0, 32'd7500);        // window reached, not exceeded
      push_at(2500, 0, 0, 32'd7501);
      push_at(-5000, 0, 0, 32'hFFFF_FFF0);
      push_at(0, 0, 0, 32'h0000_0010);      // release across the time wrap
      push_at(1, -1, 1, 32'h0000_1398);
      push_at(0, 1, 0, 32'h0000_1399);
   endtask

   task automatic send_queued();
      gyro_sample_type s;
      int              gap_len;
      while (sample_q.size() != 0) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap_len != 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap_len) @(posedge clock);
            end
         end
         s = sample_q.pop_front();
         req_ch.valid <= 1'b1;
         req_ch.rate_x <= s.x;
         req_ch.rate_y <= s.y;
         req_ch.rate_z <= s.z;
         req_ch.time_ms <= s.t;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         burst_left--;
      end
      req_ch.valid <= 1'b0;
   endtask

   // Waits until every expected result has come back, then waits out SETTLE_CYCLES.
   task automatic settle();
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_we high so back-to-back writes need no second assignment.
   task automatic write_reg(ggd_pkg::csr_index_type idx, logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [15:0] thr, logic [15:0] frac_word, logic [15:0] win,
                            logic [15:0] deb, logic [15:0] cool, int count,
                            bit poke_unmapped);
      settle();
      write_reg(ggd_pkg::CSR_TRIGGER_THRESHOLD, thr);
      write_reg(ggd_pkg::CSR_RELEASE_FRACTION, frac_word);
      write_reg(ggd_pkg::CSR_DETECT_WINDOW, win);
      write_reg(ggd_pkg::CSR_DEBOUNCE, deb);
      write_reg(ggd_pkg::CSR_COOLDOWN, cool);
      if (poke_unmapped) write_reg(CSR_UNMAPPED, 16'($urandom()));
      csr_we <= 1'b0;
      cur_thr = int'(thr);
      cur_frac = int'(frac_word[8:0]);
      queue_random(count);
      send_queued();
   endtask

   task automatic random_phase();
      int          r;
      logic [15:0] thr;
      logic [8:0]  frac;
      r = $urandom_range(0, 99);
      if (r < 10)
         thr = 16'($urandom_range(0, 60));
      else if (r < 80)
         thr = 16'($urandom_range(300, 8000));
      else
         thr = 16'($urandom_range(8000, 40000));
      r = $urandom_range(0, 99);
      if (r < 8)
         frac = '0;
      else if (r < 80)
         frac = 9'($urandom_range(32, 256));
      else
         frac = 9'($urandom_range(257, 511));
      // Upper bits of the fraction word are junk that must be dropped.
      run_phase(thr, {7'($urandom_range(0, 127)), frac}, 16'($urandom_range(0, 1500)),
                16'($urandom_range(0, 300)), 16'($urandom_range(0, 700)), 100, r[0]);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = ggd_pkg::CSR_TRIGGER_THRESHOLD;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.rate_x = '0;
      req_ch.rate_y = '0;
      req_ch.rate_z = '0;
      req_ch.time_ms = '0;
      clock_ms = '0;
      burst_left = 0;
      cur_thr = int'(ggd_pkg::THRESHOLD_RST);
      cur_frac = int'(ggd_pkg::FRACTION_RST);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_directed();
      queue_random(120);
      send_queued();
      run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 60, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 1'b1);
      repeat (6) random_phase();
      settle();

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
